// ===== sv/utf8s_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8s_pkg
// Shared types and constants for the UTF-8 sequence sanitizer.
// ----------------------------------------------------------------------------
package utf8s_pkg;

    localparam int BYTE_W          = 8;
    localparam int MAX_RUN         = 4;   // longest run one byte can release
    localparam int RUN_CNT_W       = 3;   // holds 0..MAX_RUN
    localparam int HELD_DEPTH      = 3;
    localparam int DEF_FIFO_DEPTH  = 8;

    localparam logic [BYTE_W-1:0] CONT_MASK  = 8'hC0;
    localparam logic [BYTE_W-1:0] CONT_MARK  = 8'h80;
    localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD2_MARK = 8'hC0;
    localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'hF0;
    localparam logic [BYTE_W-1:0] LEAD3_MARK = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD4_MASK = 8'hF8;
    localparam logic [BYTE_W-1:0] LEAD4_MARK = 8'hF0;

    // Run of bytes released by one input transfer; last byte of the run
    // sits at index count-1.
    typedef struct packed {
        logic [RUN_CNT_W-1:0]                count;
        logic [MAX_RUN-1:0][BYTE_W-1:0]      bytes;
    } t_run;

endpackage

// ===== sv/utf8_sequence_sanitizer.sv =====
`timescale 1ns / 1ps
// Timing: a released run starts on the output in the cycle after the input
//   transfer that completes it, behind any queued bytes, then one byte per
//   cycle while the sink is ready. Throughput: one input byte per cycle
//   while the queue has room; a ready sink and FIFO_DEPTH >= 8 never stall it.
// Reset: synchronous, active low; clears the open sequence and empties the
//   output queue.
// ----------------------------------------------------------------------------
// utf8_sequence_sanitizer
// Byte-stream filter that passes only whole UTF-8 characters.
// ----------------------------------------------------------------------------
module utf8_sequence_sanitizer #(
    parameter int FIFO_DEPTH = utf8s_pkg::DEF_FIFO_DEPTH   // power of two, >= 4
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // input stream
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    input  logic [utf8s_pkg::BYTE_W-1:0]    i_s_axis_tdata,  // [7:0] text_byte
    input  logic                            i_s_axis_tlast,  // end_of_text
    // output stream
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    output logic [utf8s_pkg::BYTE_W-1:0]    o_m_axis_tdata,  // [7:0] clean_byte
    output logic                            o_m_axis_tlast   // run_last
);
    import utf8s_pkg::*;

    logic s_xfer;
    t_run run;

    // Accept a byte whenever the queue can absorb the longest possible run,
    // independent of whether the sink is taking bytes this cycle. The queue
    // admits a byte while it has room for a full 4-byte run; a run is released
    // only once its last byte has come in, so a ready sink keeps the queue at
    // or below four bytes.
    assign s_xfer = i_s_axis_tvalid && o_s_axis_tready;

    // Track lead and continuation bytes; release a run on each completed
    // character or ASCII byte, nothing otherwise.
    utf8s_decode u_decode (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (s_xfer),
        .i_byte   (i_s_axis_tdata),
        .i_eot    (i_s_axis_tlast),
        .o_run    (run)
    );

    // Queue the released bytes and drain them one transfer per cycle while the
    // sink is ready; the final byte of each run carries tlast.
    utf8s_out_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_run   (run),
        .o_room  (o_s_axis_tready),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_byte  (o_m_axis_tdata),
        .o_last  (o_m_axis_tlast)
    );

endmodule

// ===== sv/utf8s_decode.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8s_decode
// Sequence tracker: holds open multi-byte sequences and releases whole runs.
// ----------------------------------------------------------------------------
module utf8s_decode (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_accept,
    input  logic [utf8s_pkg::BYTE_W-1:0]    i_byte,
    input  logic                            i_eot,
    output utf8s_pkg::t_run                 o_run
);
    import utf8s_pkg::*;

    logic [HELD_DEPTH-1:0][BYTE_W-1:0] r_held;
    logic [HELD_DEPTH-1:0][BYTE_W-1:0] n_held;
    logic [1:0]                        r_need;
    logic [1:0]                        n_need;
    logic [1:0]                        r_hcnt;
    logic [1:0]                        n_hcnt;
    logic                              is_cont;

    assign is_cont = (i_byte & CONT_MASK) == CONT_MARK;

    always_comb begin
        n_held      = r_held;
        n_need      = r_need;
        n_hcnt      = r_hcnt;
        o_run.count = '0;
        for (int i = 0; i < HELD_DEPTH; i++) begin
            o_run.bytes[i] = (2'(i) < r_hcnt) ? r_held[i] : i_byte;
        end
        o_run.bytes[MAX_RUN-1] = i_byte;

        if (i_accept) begin
            if (r_need != 2'd0 && is_cont) begin
                if (r_need == 2'd1) begin
                    // sequence complete: release held bytes plus this one
                    o_run.count = RUN_CNT_W'(r_hcnt) + RUN_CNT_W'(1);
                    n_need      = 2'd0;
                    n_hcnt      = 2'd0;
                end else begin
                    n_held[r_hcnt] = i_byte;
                    n_hcnt         = r_hcnt + 2'd1;
                    n_need         = r_need - 2'd1;
                end
            end else begin
                // drop any open sequence, then handle the byte afresh
                n_need = 2'd0;
                n_hcnt = 2'd0;
                if (i_byte[BYTE_W-1] == 1'b0) begin
                    o_run.count    = RUN_CNT_W'(1);
                    o_run.bytes[0] = i_byte;
                end else if ((i_byte & LEAD2_MASK) == LEAD2_MARK) begin
                    n_held[0] = i_byte;
                    n_hcnt    = 2'd1;
                    n_need    = 2'd1;
                end else if ((i_byte & LEAD3_MASK) == LEAD3_MARK) begin
                    n_held[0] = i_byte;
                    n_hcnt    = 2'd1;
                    n_need    = 2'd2;
                end else if ((i_byte & LEAD4_MASK) == LEAD4_MARK) begin
                    n_held[0] = i_byte;
                    n_hcnt    = 2'd1;
                    n_need    = 2'd3;
                end
            end
            if (i_eot) begin
                n_need = 2'd0;
                n_hcnt = 2'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_need <= 2'd0;
            r_hcnt <= 2'd0;
        end else begin
            r_need <= n_need;
            r_hcnt <= n_hcnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_held <= n_held;
    end

endmodule

// ===== sv/utf8s_out_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8s_out_fifo
// Result queue: takes a whole run per cycle, hands out one byte per cycle while the reader is ready.
// ----------------------------------------------------------------------------
module utf8s_out_fifo #(
    parameter int DEPTH = utf8s_pkg::DEF_FIFO_DEPTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  utf8s_pkg::t_run                 i_run,
    output logic                            o_room,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [utf8s_pkg::BYTE_W-1:0]    o_byte,
    output logic                            o_last
);
    import utf8s_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [DEPTH-1:0][BYTE_W:0] r_mem;
    logic [PW-1:0]              r_wr;
    logic [PW-1:0]              r_rd;
    logic [CW-1:0]              r_cnt;
    logic [PW-1:0]              n_wr;
    logic [PW-1:0]              n_rd;
    logic [CW-1:0]              n_cnt;
    logic                       pop;

    assign o_room  = r_cnt <= CW'(DEPTH - MAX_RUN);
    assign o_valid = r_cnt != '0;
    assign pop     = o_valid && i_ready;
    assign o_byte  = r_mem[r_rd][BYTE_W-1:0];
    assign o_last  = r_mem[r_rd][BYTE_W];

    always_comb begin
        n_wr  = r_wr + PW'(i_run.count);
        n_rd  = r_rd + PW'(pop);
        n_cnt = r_cnt + CW'(i_run.count) - CW'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    // write each byte of the run to consecutive slots; mark the final one
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < MAX_RUN; k++) begin
            if (RUN_CNT_W'(k) < i_run.count) begin
                r_mem[r_wr + PW'(k)] <= {(RUN_CNT_W'(k + 1) == i_run.count),
                                         i_run.bytes[k]};
            end
        end
    end

endmodule

// ===== tb/utf8_sanitizer_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_sanitizer_checker
// Watches both stream ports of the sanitizer. It predicts the clean bytes that
// each input transfer releases and checks every output transfer, in order,
// against them.
// ----------------------------------------------------------------------------
module utf8_sanitizer_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    input  logic                            i_s_axis_tready,
    input  logic [utf8s_pkg::BYTE_W-1:0]    i_s_axis_tdata,   // [7:0] text_byte
    input  logic                            i_s_axis_tlast,   // end_of_text
    input  logic                            i_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    input  logic [utf8s_pkg::BYTE_W-1:0]    i_m_axis_tdata,   // [7:0] clean_byte
    input  logic                            i_m_axis_tlast,   // run_last
    output int                              o_fail_count,
    output int                              o_pending
);
    import utf8s_pkg::*;

    localparam int REPORT_LIMIT = 10;

    typedef enum logic [2:0] {
        CLS_ASCII,
        CLS_CONT,
        CLS_LEAD2,
        CLS_LEAD3,
        CLS_LEAD4,
        CLS_INVALID
    } t_byte_class;

    typedef struct packed {
        logic [BYTE_W-1:0]  clean_byte;
        logic               run_last;
    } t_clean_out;

    t_clean_out         clean_out_q [$];
    logic [BYTE_W-1:0]  seq_bytes [HELD_DEPTH];
    logic [1:0]         missing_conts;
    logic [1:0]         seq_len_held;
    int                 mismatch_cnt;

    function automatic t_byte_class classify_byte(input logic [BYTE_W-1:0] b);
        if (b[BYTE_W-1] == 1'b0)
            return CLS_ASCII;
        if ((b & CONT_MASK) == CONT_MARK)
            return CLS_CONT;
        if ((b & LEAD2_MASK) == LEAD2_MARK)
            return CLS_LEAD2;
        if ((b & LEAD3_MASK) == LEAD3_MARK)
            return CLS_LEAD3;
        if ((b & LEAD4_MASK) == LEAD4_MARK)
            return CLS_LEAD4;
        return CLS_INVALID;
    endfunction

    // Append one expected output transfer at the back of the queue.
    task automatic queue_clean(input logic [BYTE_W-1:0] b, input logic last);
        t_clean_out item;
        item.clean_byte = b;
        item.run_last   = last;
        clean_out_q     = {clean_out_q, item};
    endtask

    task automatic open_sequence(input logic [BYTE_W-1:0] lead, input logic [1:0] conts);
        seq_bytes[0]  = lead;
        seq_len_held  = 2'd1;
        missing_conts = conts;
    endtask

    // Advance the sequence state by one text byte and queue what it releases.
    task automatic filter_text_byte(input logic [BYTE_W-1:0] b, input logic eot);
        t_byte_class cls;
        cls = classify_byte(b);
        if (missing_conts != 2'd0 && cls == CLS_CONT) begin
            if (missing_conts == 2'd1) begin
                for (int i = 0; i < int'(seq_len_held); i++)
                    queue_clean(seq_bytes[i], 1'b0);
                queue_clean(b, 1'b1);
                missing_conts = 2'd0;
                seq_len_held  = 2'd0;
            end else begin
                seq_bytes[seq_len_held] = b;
                seq_len_held  = seq_len_held + 2'd1;
                missing_conts = missing_conts - 2'd1;
            end
        end else begin
            // a broken sequence is dropped and the byte starts afresh
            missing_conts = 2'd0;
            seq_len_held  = 2'd0;
            case (cls)
                CLS_ASCII: queue_clean(b, 1'b1);
                CLS_LEAD2: open_sequence(b, 2'd1);
                CLS_LEAD3: open_sequence(b, 2'd2);
                CLS_LEAD4: open_sequence(b, 2'd3);
                default: ;
            endcase
        end
        if (eot) begin
            missing_conts = 2'd0;
            seq_len_held  = 2'd0;
        end
    endtask

    always @(posedge i_clk) begin : watch_ports
        t_clean_out want;
        if (!i_rst_n) begin
            clean_out_q.delete();
            missing_conts = 2'd0;
            seq_len_held  = 2'd0;
        end else begin
            if (i_s_axis_tvalid && i_s_axis_tready)
                filter_text_byte(i_s_axis_tdata, i_s_axis_tlast);
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                if (clean_out_q.size() == 0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= REPORT_LIMIT)
                        $display("%0t: unexpected output transfer, clean_byte %02h run_last %0d",
                                 $time, i_m_axis_tdata, i_m_axis_tlast);
                end else begin
                    want = clean_out_q.pop_front();
                    if (want.clean_byte !== i_m_axis_tdata ||
                        want.run_last !== i_m_axis_tlast) begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= REPORT_LIMIT)
                            $display("%0t: clean_byte exp %02h got %02h, run_last exp %0d got %0d",
                                     $time, want.clean_byte, i_m_axis_tdata,
                                     want.run_last, i_m_axis_tlast);
                    end
                end
            end
        end
        o_pending    <= clean_out_q.size();
        o_fail_count <= mismatch_cnt;
    end

endmodule

// ===== tb/tb_utf8_sequence_sanitizer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_utf8_sequence_sanitizer
// Feeds the sanitizer a directed set of edge cases and then a random stream of
// mostly well-formed characters with broken sequences and noise mixed in. Both
// ports idle at random; the checker predicts and compares every transfer.
// ----------------------------------------------------------------------------
module tb_utf8_sequence_sanitizer;

    import utf8s_pkg::*;

    localparam int TOTAL_ITEMS  = 186;      // directed part plus about 160 random
    localparam int CYCLE_LIMIT  = 200000;
    localparam int IDLE_PCT     = 32;
    localparam int TAIL_CYCLES  = 16;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_s_axis_tvalid;
    logic               o_s_axis_tready;
    logic [BYTE_W-1:0]  i_s_axis_tdata;     // [7:0] text_byte
    logic               i_s_axis_tlast;     // end_of_text
    logic               o_m_axis_tvalid;
    logic               i_m_axis_tready;
    logic [BYTE_W-1:0]  o_m_axis_tdata;     // [7:0] clean_byte
    logic               o_m_axis_tlast;     // run_last

    int                 fail_count;
    int                 pending_cnt;
    int                 cycle_cnt;
    int                 sent_cnt;
    logic               calm = 1'b0;        // high: neither side idles

    utf8_sequence_sanitizer i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    utf8_sanitizer_checker i_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .i_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .i_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .i_m_axis_tdata  (o_m_axis_tdata),
        .i_m_axis_tlast  (o_m_axis_tlast),
        .o_fail_count    (fail_count),
        .o_pending       (pending_cnt)
    );

    // 4 ns clock
    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // Count cycles, open a quiet window in mid-run and enforce the time limit.
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        calm      <= (cycle_cnt >= 200 && cycle_cnt < 360);
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Sink side: stall at random outside the quiet window.
    always @(posedge i_clk) begin
        i_m_axis_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // Roughly one text end in twelve bytes, so ends land inside sequences too.
    function automatic logic pick_eot();
        return ($urandom_range(0, 11) == 0);
    endfunction

    // Present one byte and hold it until the sanitizer takes it. Ready is
    // sampled at the falling edge, where it has settled for the next rising
    // edge, so the handshake never depends on event order.
    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic eot);
        logic took;
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= b;
        i_s_axis_tlast  <= eot;
        do begin
            @(negedge i_clk);
            took = o_s_axis_tready;
            @(posedge i_clk);
        end while (!took);
        sent_cnt++;
    endtask

    // Send a lead byte for a character of len bytes and then conts
    // continuation bytes with random payload; conts < len-1 truncates it.
    task automatic send_char(input int len, input int conts);
        logic [31:0]       r;
        logic [BYTE_W-1:0] lead;
        r = $urandom;
        case (len)
            2:       lead = {3'b110, r[4:0]};
            3:       lead = {4'b1110, r[3:0]};
            default: lead = {5'b11110, r[2:0]};
        endcase
        send_byte(lead, pick_eot());
        for (int k = 0; k < conts; k++) begin
            r = $urandom;
            send_byte({2'b10, r[5:0]}, pick_eot());
        end
    endtask

    initial begin : stimulus
        logic [31:0] r;
        int          pick;
        int          len;

        sent_cnt         = 0;
        i_rst_n         <= 1'b0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= '0;
        i_s_axis_tlast  <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // ASCII extremes, stray continuation, invalid leads
        send_byte(8'h00, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hF8, 1'b0);
        send_byte(8'hFF, 1'b0);
        // complete 2, 3 and 4 byte characters, lowest 2-byte and highest 4-byte leads
        send_byte(8'hC0, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hE2, 1'b0);
        send_byte(8'h82, 1'b0);
        send_byte(8'hAC, 1'b0);
        send_byte(8'hF7, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hBF, 1'b0);
        // sequence broken by an ASCII byte, which still passes
        send_byte(8'hE2, 1'b0);
        send_byte(8'h41, 1'b0);
        // sequence broken by a new lead, which then completes
        send_byte(8'hF0, 1'b0);
        send_byte(8'h9F, 1'b0);
        send_byte(8'hC3, 1'b0);
        send_byte(8'hA9, 1'b0);
        // text ends inside a sequence; the next continuation is stray
        send_byte(8'hE0, 1'b0);
        send_byte(8'hA0, 1'b1);
        send_byte(8'h80, 1'b0);
        // text ends on ASCII and on a completing continuation
        send_byte(8'h5A, 1'b1);
        send_byte(8'hC2, 1'b0);
        send_byte(8'h80, 1'b1);

        // Mostly well-formed characters; the rest truncated sequences and noise.
        while (sent_cnt < TOTAL_ITEMS) begin
            pick = $urandom_range(0, 99);
            r    = $urandom;
            if (pick < 20) begin
                send_byte({1'b0, r[6:0]}, pick_eot());
            end else if (pick < 40) begin
                send_char(2, 1);
            end else if (pick < 58) begin
                send_char(3, 2);
            end else if (pick < 75) begin
                send_char(4, 3);
            end else if (pick < 87) begin
                len = $urandom_range(2, 4);
                send_char(len, $urandom_range(0, len - 2));
            end else begin
                send_byte(r[7:0], pick_eot());
            end
        end
        i_s_axis_tvalid <= 1'b0;

        // Let the checker take in the final transfer, drain, then watch a
        // little longer for anything spurious.
        @(posedge i_clk);
        while (pending_cnt != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && pending_cnt == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
